[rtl/mlsq_pkg.sv]
// Shared command codes, status codes and controller/datapath interface types.
package mlsq_pkg;

   localparam logic [1:0] KIND_CREATE = 2'd0;
   localparam logic [1:0] KIND_PUSH   = 2'd1;
   localparam logic [1:0] KIND_POP    = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EXISTS  = 3'd1;
   localparam logic [2:0] ST_NO_LIST = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic rd;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic early;
   } dp_stat_type;

endpackage

[rtl/multi_list_stack_queue_engine_unit.sv]
// Top level of the linked list stack and queue engine.
// Create, errors and unused codes finish in the EXEC state; a good push or pop also passes
// through the RD state, set by the registered read of the pool memories before the pointer update.
// A new item is taken only in the idle state; the engine waits while the result register is full.
// Synchronous active-high reset empties all lists and rebuilds the free list at once;
// the pool memories need no clearing pass.
module multi_list_stack_queue_engine_unit import mlsq_pkg::*; #(
   parameter int NUM_LISTS    = 8,
   parameter int POOL_ENTRIES = 64,
   parameter int DATA_WIDTH   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [2:0]  req_list_id,
   input  logic        req_list_type,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_popped_valid,
   output logic [31:0] rsp_popped_value
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   mlsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mlsq_datapath #(
      .NUM_LISTS    (NUM_LISTS),
      .POOL_ENTRIES (POOL_ENTRIES),
      .DATA_WIDTH   (DATA_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_kind),
      .req_list_id      (req_list_id),
      .req_list_type    (req_list_type),
      .req_value        (req_value),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_popped_valid (rsp_popped_valid),
      .rsp_popped_value (rsp_popped_value)
   );

endmodule

[rtl/mlsq_ctrl.sv]
// Controller state machine that sequences each command through the datapath.
module mlsq_ctrl import mlsq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_RD   = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.early) begin
               if (out_free) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_OUT;
               end
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd = 1'b1;
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/mlsq_datapath.sv]
// List table, entry pool memories, free list and result register.
module mlsq_datapath import mlsq_pkg::*; #(
   parameter int NUM_LISTS    = 8,
   parameter int POOL_ENTRIES = 64,
   parameter int DATA_WIDTH   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   req_kind,
   input  logic [2:0]   req_list_id,
   input  logic         req_list_type,
   input  logic [31:0]  req_value,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   output logic [2:0]   rsp_status,
   output logic         rsp_popped_valid,
   output logic [31:0]  rsp_popped_value
);

   localparam int NLE = (NUM_LISTS < 8) ? NUM_LISTS : 8;
   localparam int LW  = (NLE > 1) ? $clog2(NLE) : 1;
   localparam int PW  = $clog2(POOL_ENTRIES);
   localparam int CW  = $clog2(POOL_ENTRIES + 1);
   localparam int SW  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

   logic [1:0]    kind_ff, kind_in;
   logic [2:0]    lid_ff, lid_in;
   logic          qtype_ff, qtype_in;
   logic [SW-1:0] val_ff, val_in;
   logic [2:0]    status_ff, status_in;
   logic          pop_done_ff, pop_done_in;
   logic [PW-1:0] e_ff, e_in;
   logic          fresh_hit_ff, fresh_hit_in;

   logic [NLE-1:0] exists_ff, exists_in;
   logic [NLE-1:0] isq_ff, isq_in;
   logic [CW-1:0]  count_ff [NLE];
   logic [CW-1:0]  count_in [NLE];
   logic [PW-1:0]  head_ff [NLE];
   logic [PW-1:0]  head_in [NLE];
   logic [PW-1:0]  tail_ff [NLE];
   logic [PW-1:0]  tail_in [NLE];

   logic [PW-1:0] free_head_ff, free_head_in;
   logic [CW-1:0] free_count_ff, free_count_in;
   logic [CW-1:0] fresh_ff, fresh_in;

   logic [PW-1:0] next_mem [POOL_ENTRIES];
   logic [SW-1:0] data_mem [POOL_ENTRIES];
   logic [PW-1:0] next_rd_ff;
   logic [SW-1:0] data_rd_ff;

   logic [2:0]    rsp_status_ff;
   logic          rsp_popped_valid_ff;
   logic [31:0]   rsp_popped_value_ff;

   logic [LW-1:0] lidx;
   logic          in_range, present, is_create, is_push, is_pop;
   logic [2:0]    exec_status;
   logic [PW-1:0] rd_addr;
   logic [CW-1:0] e_inc;
   logic [PW-1:0] fresh_next;
   logic          next_we, data_we;
   logic [PW-1:0] next_waddr, next_wdata;
   logic [2:0]    res_status;
   logic          res_pv;

   assign lidx      = LW'(lid_ff);
   assign in_range  = (32'(lid_ff) < NUM_LISTS);
   assign present   = in_range && exists_ff[lidx];
   assign is_create = (kind_ff == KIND_CREATE);
   assign is_push   = (kind_ff == KIND_PUSH);
   assign is_pop    = (kind_ff == KIND_POP);
   assign rd_addr   = is_push ? free_head_ff : head_ff[lidx];
   assign e_inc     = CW'(e_ff) + 1'b1;
   assign fresh_next = (e_inc == CW'(POOL_ENTRIES)) ? '0 : PW'(e_inc);

   always_comb begin
      exec_status = ST_OK;
      priority if (is_create) begin
         if (!in_range) begin
            exec_status = ST_NO_LIST;
         end else if (present) begin
            exec_status = ST_EXISTS;
         end
      end else if (is_push) begin
         if (!present) begin
            exec_status = ST_NO_LIST;
         end else if (free_count_ff == '0) begin
            exec_status = ST_FULL;
         end
      end else if (is_pop) begin
         if (!present) begin
            exec_status = ST_NO_LIST;
         end else if (count_ff[lidx] == '0) begin
            exec_status = ST_EMPTY;
         end
      end else begin
         exec_status = ST_OK;
      end
   end

   assign stat.early = (exec_status != ST_OK) || !(is_push || is_pop);

   always_comb begin
      kind_in       = kind_ff;
      lid_in        = lid_ff;
      qtype_in      = qtype_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      pop_done_in   = pop_done_ff;
      e_in          = e_ff;
      fresh_hit_in  = fresh_hit_ff;
      exists_in     = exists_ff;
      isq_in        = isq_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      fresh_in      = fresh_ff;
      next_we       = 1'b0;
      next_waddr    = e_ff;
      next_wdata    = '0;
      data_we       = 1'b0;

      if (cmd.load_req) begin
         kind_in  = req_kind;
         lid_in   = req_list_id;
         qtype_in = req_list_type;
         val_in   = req_value[SW-1:0];
      end

      if (cmd.exec) begin
         status_in    = exec_status;
         pop_done_in  = 1'b0;
         e_in         = rd_addr;
         fresh_hit_in = (CW'(free_head_ff) == fresh_ff);
         if (is_create && exec_status == ST_OK) begin
            exists_in[lidx] = 1'b1;
            isq_in[lidx]    = qtype_ff;
            count_in[lidx]  = '0;
         end
      end

      if (cmd.rd) begin
         if (is_push) begin
            free_head_in   = fresh_hit_ff ? fresh_next : next_rd_ff;
            free_count_in  = free_count_ff - 1'b1;
            data_we        = 1'b1;
            count_in[lidx] = count_ff[lidx] + 1'b1;
            if (fresh_hit_ff) begin
               fresh_in = fresh_ff + 1'b1;
            end
            if (isq_ff[lidx]) begin
               if (count_ff[lidx] == '0) begin
                  head_in[lidx] = e_ff;
               end else begin
                  next_we    = 1'b1;
                  next_waddr = tail_ff[lidx];
                  next_wdata = e_ff;
               end
               tail_in[lidx] = e_ff;
            end else begin
               next_we    = 1'b1;
               next_waddr = e_ff;
               next_wdata = head_ff[lidx];
               if (count_ff[lidx] == '0) begin
                  tail_in[lidx] = e_ff;
               end
               head_in[lidx] = e_ff;
            end
         end else begin
            if (count_ff[lidx] != CW'(1)) begin
               head_in[lidx] = next_rd_ff;
            end
            count_in[lidx] = count_ff[lidx] - 1'b1;
            next_we        = 1'b1;
            next_waddr     = e_ff;
            next_wdata     = free_head_ff;
            free_head_in   = e_ff;
            free_count_in  = free_count_ff + 1'b1;
            pop_done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exists_ff     <= '0;
         isq_ff        <= '0;
         count_ff      <= '{default: '0};
         free_head_ff  <= '0;
         free_count_ff <= CW'(POOL_ENTRIES);
         fresh_ff      <= '0;
         pop_done_ff   <= 1'b0;
      end else begin
         exists_ff     <= exists_in;
         isq_ff        <= isq_in;
         count_ff      <= count_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         fresh_ff      <= fresh_in;
         pop_done_ff   <= pop_done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      lid_ff       <= lid_in;
      qtype_ff     <= qtype_in;
      val_ff       <= val_in;
      status_ff    <= status_in;
      e_ff         <= e_in;
      fresh_hit_ff <= fresh_hit_in;
      head_ff      <= head_in;
      tail_ff      <= tail_in;
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (data_we) begin
         data_mem[e_ff] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         next_rd_ff <= next_mem[rd_addr];
         data_rd_ff <= data_mem[rd_addr];
      end
   end

   assign res_status = cmd.exec ? exec_status : status_ff;
   assign res_pv     = cmd.exec ? 1'b0 : (cmd.rd ? is_pop : pop_done_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff       <= res_status;
         rsp_popped_valid_ff <= res_pv;
         rsp_popped_value_ff <= res_pv ? 32'(data_rd_ff) : '0;
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_valid = rsp_popped_valid_ff;
   assign rsp_popped_value = rsp_popped_value_ff;

endmodule
